// ===== design/i2cmbs_pkg.sv =====
// Shared types and constants for the I2C master bit sequencer.
`timescale 1ns / 1ps
package i2cmbs_pkg;

   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 16;
   localparam int CSR_DATA_W  = 16;

   localparam logic [15:0] RESET_PULSES = 16'd16;
   localparam logic [6:0]  DEV_ADDR_RESET = 7'h25;
   localparam logic [15:0] BUS_WAIT_RESET = 16'd25000;

   typedef enum logic [3:0] {
      OP_NONE       = 4'd0,
      OP_INIT       = 4'd1,
      OP_START      = 4'd2,
      OP_RESTART    = 4'd3,
      OP_STOP       = 4'd4,
      OP_SEND_ADDR  = 4'd5,
      OP_SEND_BYTE  = 4'd6,
      OP_READ_ACK   = 4'd7,
      OP_READ_NAK   = 4'd8,
      OP_BUS_RESET  = 4'd9,
      OP_WAIT_FREE  = 4'd10
   } opcode_type;

   typedef enum logic {
      CSR_DEV_ADDR = 1'b0,
      CSR_BUS_WAIT = 1'b1
   } csr_index_type;

   // Packed from the highest field down, so the opcode sits in the lowest bits.
   typedef struct packed {
      logic       sda_in;
      logic       read_not_write;
      logic [7:0] tx_byte;
      logic [3:0] opcode;
   } req_item_type;

   typedef struct packed {
      logic       rejected;
      logic       bus_timeout;
      logic [7:0] rx_byte;
      logic       nak_seen;
      logic       done_res;
      logic       busy_res;
      logic       sda_out;
      logic       scl_out;
   } rsp_item_type;

   typedef struct packed {
      logic [6:0]  device_address;
      logic [15:0] bus_wait_ticks;
   } cfg_type;

   // Bit slot within a transmitted bit: 0 set SDA, 1 raise SCL, 2 drop SCL.
   function automatic logic [1:0] bit_slot(input logic [5:0] p);
      logic [1:0] r;
      case (p)
         6'd0, 6'd3, 6'd6, 6'd9, 6'd12, 6'd15, 6'd18, 6'd21:  r = 2'd0;
         6'd1, 6'd4, 6'd7, 6'd10, 6'd13, 6'd16, 6'd19, 6'd22: r = 2'd1;
         default:                                             r = 2'd2;
      endcase
      return r;
   endfunction

endpackage

// ===== design/i2c_master_bit_sequencer_unit.sv =====
// I2C master bit sequencer: top level.
`timescale 1ns / 1ps
// Usage:
//  - req channel: one transaction per tick. It carries the sampled SDA level
//    and, while the sequencer is idle, a command (init, start, restart, stop,
//    send address, send byte, read with ACK or NAK, bus reset, wait free).
//  - rsp channel: exactly one report per tick, in order: SCL and SDA drive,
//    busy, done, NAK seen, last received byte, bus timeout and rejected.
//  - csr channel: index 0 device address, index 1 bus wait ticks; always
//    ready. Write it only while no tick is in flight.
//  - Path: an accepted transaction is held in the input register, and its
//    report is computed from it and presented from the result register.
//  - Throughput: one tick per clock cycle while rsp_tready is high, set by
//    the combinational step of the sequencer state between the two registers.
//  - Reset: both stages empty, sequencer idle with SCL and SDA released,
//    device address 0x25 and bus wait 25000 ticks.
//  - Stall: when rsp_tready is low the report holds; one more tick waits in
//    the input register, then req_tready drops until the report leaves.
module i2c_master_bit_sequencer_unit
   import i2cmbs_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // opcode[3:0], tx_byte[11:4], read_not_write[12], sda_in[13], zero[15:14]
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // scl_out[0], sda_out[1], busy_res[2], done_res[3], nak_seen[4],
   // rx_byte[12:5], bus_timeout[13], rejected[14], zero[15]
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type      cfg;
   req_item_type item;
   rsp_item_type result;
   logic         item_valid;
   logic         take;
   logic         advance;

   // Step the sequencer when a tick is held and the result register is free.
   assign advance = item_valid && take;

   i2cmbs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   i2cmbs_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   i2cmbs_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item),
      .cfg     (cfg),
      .result  (result)
   );

   i2cmbs_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .result     (result),
      .take       (take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== design/i2cmbs_csr.sv =====
// Configuration register file: device address and bus wait timeout.
`timescale 1ns / 1ps
module i2cmbs_csr
   import i2cmbs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output cfg_type               cfg
);

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_DEV_ADDR: cfg_in.device_address = csr_data[6:0];
            CSR_BUS_WAIT: cfg_in.bus_wait_ticks = csr_data;
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_address <= DEV_ADDR_RESET;
         cfg_ff.bus_wait_ticks <= BUS_WAIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== design/i2cmbs_in_reg.sv =====
// Input register stage for tick transactions.
`timescale 1ns / 1ps
module i2cmbs_in_reg
   import i2cmbs_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   advance,
   output logic                   item_valid,
   output req_item_type           item
);

   logic         valid_ff, valid_in;
   req_item_type item_ff;

   // Take a new tick when empty or when the held one moves on this cycle.
   assign req_tready = !valid_ff || advance;
   assign valid_in   = req_tready ? req_tvalid : valid_ff;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         item_ff <= req_item_type'(req_tdata[$bits(req_item_type)-1:0]);
      end
   end

endmodule

// ===== design/i2cmbs_core.sv =====
// Line sequencer state and per-tick step logic.
`timescale 1ns / 1ps
module i2cmbs_core
   import i2cmbs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  req_item_type item,
   input  cfg_type      cfg,
   output rsp_item_type result
);

   opcode_type  cmd_ff, cmd_in;
   logic [5:0]  phase_ff, phase_in;
   logic [7:0]  shift_ff, shift_in;
   logic        scl_ff, scl_in;
   logic        sda_lvl_ff, sda_lvl_in;
   logic [15:0] wait_ff, wait_in;
   logic        nak_ff, nak_in;
   logic [7:0]  rxb_ff, rxb_in;

   logic [5:0]  p, next_phase, pm3;
   logic [1:0]  stop_q;
   logic        do_stop, done, timeout, rejected;

   always_comb begin
      cmd_in     = cmd_ff;
      phase_in   = phase_ff;
      shift_in   = shift_ff;
      scl_in     = scl_ff;
      sda_lvl_in = sda_lvl_ff;
      wait_in    = wait_ff;
      nak_in     = nak_ff;
      rxb_in     = rxb_ff;
      rejected   = 1'b0;
      done       = 1'b0;
      timeout    = 1'b0;
      do_stop    = 1'b0;
      stop_q     = 2'd0;

      // Launch a command only from idle; any command while busy is dropped.
      if (cmd_ff != OP_NONE) begin
         rejected = (item.opcode != OP_NONE);
      end else if (item.opcode >= OP_INIT && item.opcode <= OP_WAIT_FREE) begin
         cmd_in   = opcode_type'(item.opcode);
         phase_in = 6'd0;
         case (opcode_type'(item.opcode))
            OP_SEND_ADDR:             shift_in = {cfg.device_address, item.read_not_write};
            OP_SEND_BYTE:             shift_in = item.tx_byte;
            OP_READ_ACK, OP_READ_NAK: shift_in = 8'd0;
            OP_WAIT_FREE:             wait_in  = 16'd0;
            default:                  shift_in = shift_ff;
         endcase
      end

      p          = phase_in;
      pm3        = p - 6'd3;
      next_phase = p + 6'd1;

      unique case (cmd_in)
         OP_INIT: begin
            if (p == 6'd0) sda_lvl_in = 1'b1;
            else begin
               scl_in = 1'b1;
               done   = 1'b1;
            end
         end
         OP_START: begin
            if (p == 6'd0) sda_lvl_in = 1'b0;
            else begin
               scl_in = 1'b0;
               done   = 1'b1;
            end
         end
         OP_RESTART: begin
            if (p == 6'd0)      sda_lvl_in = 1'b1;
            else if (p == 6'd1) scl_in = 1'b1;
            else if (p == 6'd2) sda_lvl_in = 1'b0;
            else begin
               scl_in = 1'b0;
               done   = 1'b1;
            end
         end
         OP_STOP: begin
            do_stop = 1'b1;
            stop_q  = p[1:0];
         end
         OP_SEND_ADDR, OP_SEND_BYTE: begin
            if (p < 6'd24) begin
               case (bit_slot(p))
                  2'd0: begin
                     sda_lvl_in = shift_in[7];
                     shift_in   = {shift_in[6:0], 1'b0};
                  end
                  2'd1:    scl_in = 1'b1;
                  default: scl_in = 1'b0;
               endcase
            end else if (p == 6'd24) begin
               sda_lvl_in = 1'b1;
            end else if (p == 6'd25) begin
               scl_in = 1'b1;
            end else begin
               nak_in = item.sda_in;
               scl_in = 1'b0;
               done   = 1'b1;
            end
         end
         OP_READ_ACK, OP_READ_NAK: begin
            if (p < 6'd16) begin
               if (!p[0]) begin
                  scl_in = 1'b1;
               end else begin
                  shift_in = {shift_in[6:0], item.sda_in};
                  scl_in   = 1'b0;
                  if (p == 6'd15) rxb_in = shift_in;
               end
            end else if (cmd_in == OP_READ_ACK) begin
               if (p == 6'd16)      sda_lvl_in = 1'b0;
               else if (p == 6'd17) scl_in = 1'b1;
               else if (p == 6'd18) scl_in = 1'b0;
               else begin
                  sda_lvl_in = 1'b1;
                  done       = 1'b1;
               end
            end else begin
               if (p == 6'd16)      sda_lvl_in = 1'b1;
               else if (p == 6'd17) scl_in = 1'b1;
               else begin
                  scl_in = 1'b0;
                  done   = 1'b1;
               end
            end
         end
         OP_BUS_RESET: begin
            if (p == 6'd0) begin
               sda_lvl_in = 1'b1;
               wait_in    = 16'd0;
            end else if (p == 6'd1) begin
               scl_in = 1'b0;
            end else if (p == 6'd2) begin
               scl_in     = 1'b1;
               wait_in    = wait_in + 16'd1;
               next_phase = (wait_in < RESET_PULSES) ? 6'd1 : 6'd3;
            end else begin
               do_stop = 1'b1;
               stop_q  = pm3[1:0];
            end
         end
         OP_WAIT_FREE: begin
            if (item.sda_in) begin
               done = 1'b1;
            end else begin
               wait_in = wait_in + 16'd1;
               if (wait_in >= cfg.bus_wait_ticks) begin
                  timeout = 1'b1;
                  done    = 1'b1;
               end
            end
         end
         default: done = 1'b0;
      endcase

      // Stop sequence: SCL low, SDA low, SCL high, SDA high.
      if (do_stop) begin
         case (stop_q)
            2'd0:    scl_in = 1'b0;
            2'd1:    sda_lvl_in = 1'b0;
            2'd2:    scl_in = 1'b1;
            default: begin
               sda_lvl_in = 1'b1;
               done       = 1'b1;
            end
         endcase
      end

      if (cmd_in != OP_NONE) begin
         if (done) begin
            cmd_in   = OP_NONE;
            phase_in = 6'd0;
         end else begin
            phase_in = next_phase;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff     <= OP_NONE;
         phase_ff   <= 6'd0;
         shift_ff   <= 8'd0;
         scl_ff     <= 1'b1;
         sda_lvl_ff <= 1'b1;
         wait_ff    <= 16'd0;
         nak_ff     <= 1'b0;
         rxb_ff     <= 8'd0;
      end else if (advance) begin
         cmd_ff     <= cmd_in;
         phase_ff   <= phase_in;
         shift_ff   <= shift_in;
         scl_ff     <= scl_in;
         sda_lvl_ff <= sda_lvl_in;
         wait_ff    <= wait_in;
         nak_ff     <= nak_in;
         rxb_ff     <= rxb_in;
      end
   end

   always_comb begin
      result.scl_out     = scl_in;
      result.sda_out     = sda_lvl_in;
      result.busy_res    = (cmd_in != OP_NONE);
      result.done_res    = done;
      result.nak_seen    = nak_in;
      result.rx_byte     = rxb_in;
      result.bus_timeout = timeout;
      result.rejected    = rejected;
   end

endmodule

// ===== design/i2cmbs_out_reg.sv =====
// Result register stage for report transactions.
`timescale 1ns / 1ps
module i2cmbs_out_reg
   import i2cmbs_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  rsp_item_type           result,
   output logic                   take,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   logic         valid_ff, valid_in;
   rsp_item_type data_ff;

   // Free to load when empty or when the held report leaves this cycle.
   assign take       = !valid_ff || rsp_tready;
   assign valid_in   = load ? 1'b1 : (valid_ff && !rsp_tready);
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - $bits(rsp_item_type)){1'b0}}, data_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

endmodule

// ===== design/i2cmbs_checker.sv =====
// Port-level checks for the I2C master bit sequencer, bound to the top level.
`timescale 1ns / 1ps
module i2cmbs_checker
   import i2cmbs_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   rsp_item_type rsp;
   assign rsp = rsp_item_type'(rsp_tdata[$bits(rsp_item_type)-1:0]);

   // A finished command leaves the sequencer idle on the same tick.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp.done_res && rsp.busy_res))
      else $error("done reported while still busy");

   // A timeout only ends a command.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp.bus_timeout) |-> rsp.done_res)
      else $error("bus timeout without done");

   // Reset empties the result stage.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("report present after reset");

   // A stalled report holds.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled report changed");

endmodule

bind i2c_master_bit_sequencer_unit i2cmbs_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
